// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

   // default list capacity
   localparam int DEF_CAPACITY = 16;

   localparam int VALUE_W = 32;

   // command codes
   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_SHOW      = 3'd2,
      CMD_REM_FRONT = 3'd3,
      CMD_REM_BACK  = 3'd4,
      CMD_REM_VALUE = 3'd5
   } cmd_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_FRONT,
      S_POP_BACK,
      S_SHOW,
      S_FIND,
      S_SHIFT
   } state_type;

   // read address select
   typedef enum logic [1:0] {
      RD_FRONT,
      RD_BACK,
      RD_NEXT
   } rd_sel_type;

   // write address select
   typedef enum logic [1:0] {
      WR_FRONT,
      WR_BACK,
      WR_PREV
   } wr_sel_type;

   // result element select
   typedef enum logic [1:0] {
      EL_ZERO,
      EL_READ,
      EL_SAVED
   } elem_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic         ld;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic         head_inc;
      logic         head_dec;
      logic         cnt_inc;
      logic         cnt_dec;
      logic         idx_inc;
      logic         save_elem;
      logic         emit;
      elem_sel_type elem_sel;
      status_type   status;
      logic         last;
   } dp_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic full;
      logic match;
      logic idx_last;
   } dp_stat_type;

endpackage

// ===== rtl/bdq_ctrl.sv =====
module bdq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_command,
   input  bdq_pkg::dp_stat_type stat,
   output bdq_pkg::dp_ctrl_type ctrl,
   output logic                 busy
);

   bdq_pkg::state_type state_ff, state_in;
   bdq_pkg::cmd_type   cmd;

   assign cmd  = bdq_pkg::cmd_type'(req_command);
   assign busy = (state_ff != bdq_pkg::S_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdq_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (start && !stat.empty) begin
               case (cmd)
                  bdq_pkg::CMD_SHOW:      state_in = bdq_pkg::S_SHOW;
                  bdq_pkg::CMD_REM_FRONT: state_in = bdq_pkg::S_POP_FRONT;
                  bdq_pkg::CMD_REM_BACK:  state_in = bdq_pkg::S_POP_BACK;
                  bdq_pkg::CMD_REM_VALUE: state_in = bdq_pkg::S_FIND;
                  default:                state_in = bdq_pkg::S_IDLE;
               endcase
            end
         end
         bdq_pkg::S_POP_FRONT,
         bdq_pkg::S_POP_BACK: state_in = bdq_pkg::S_IDLE;
         bdq_pkg::S_SHOW: begin
            if (stat.idx_last) state_in = bdq_pkg::S_IDLE;
         end
         bdq_pkg::S_FIND: begin
            if (stat.match && !stat.idx_last) begin
               state_in = bdq_pkg::S_SHIFT;
            end else if (stat.idx_last) begin
               state_in = bdq_pkg::S_IDLE;
            end
         end
         bdq_pkg::S_SHIFT: begin
            if (stat.idx_last) state_in = bdq_pkg::S_IDLE;
         end
         default: state_in = bdq_pkg::S_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      ctrl = '0;
      case (state_ff)
         bdq_pkg::S_IDLE: begin
            if (start) begin
               ctrl.ld = 1'b1;
               case (cmd)
                  bdq_pkg::CMD_INS_FRONT,
                  bdq_pkg::CMD_INS_BACK: begin
                     ctrl.emit = 1'b1;
                     ctrl.last = 1'b1;
                     if (stat.full) begin
                        ctrl.status = bdq_pkg::ST_FULL;
                     end else begin
                        ctrl.status  = bdq_pkg::ST_OK;
                        ctrl.wr_en   = 1'b1;
                        ctrl.cnt_inc = 1'b1;
                        if (cmd == bdq_pkg::CMD_INS_FRONT) begin
                           ctrl.wr_sel   = bdq_pkg::WR_FRONT;
                           ctrl.head_dec = 1'b1;
                        end else begin
                           ctrl.wr_sel = bdq_pkg::WR_BACK;
                        end
                     end
                  end
                  bdq_pkg::CMD_SHOW,
                  bdq_pkg::CMD_REM_FRONT,
                  bdq_pkg::CMD_REM_BACK,
                  bdq_pkg::CMD_REM_VALUE: begin
                     if (stat.empty) begin
                        ctrl.emit   = 1'b1;
                        ctrl.last   = 1'b1;
                        ctrl.status = bdq_pkg::ST_EMPTY;
                     end else begin
                        ctrl.rd_en  = 1'b1;
                        ctrl.rd_sel = (cmd == bdq_pkg::CMD_REM_BACK) ?
                                      bdq_pkg::RD_BACK : bdq_pkg::RD_FRONT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         bdq_pkg::S_POP_FRONT,
         bdq_pkg::S_POP_BACK: begin
            ctrl.emit     = 1'b1;
            ctrl.last     = 1'b1;
            ctrl.elem_sel = bdq_pkg::EL_READ;
            ctrl.cnt_dec  = 1'b1;
            ctrl.head_inc = (state_ff == bdq_pkg::S_POP_FRONT);
         end
         bdq_pkg::S_SHOW: begin
            ctrl.emit     = 1'b1;
            ctrl.elem_sel = bdq_pkg::EL_READ;
            ctrl.last     = stat.idx_last;
            if (!stat.idx_last) begin
               ctrl.rd_en   = 1'b1;
               ctrl.rd_sel  = bdq_pkg::RD_NEXT;
               ctrl.idx_inc = 1'b1;
            end
         end
         bdq_pkg::S_FIND: begin
            if (stat.match && stat.idx_last) begin
               // hit on the back entry: nothing to close up
               ctrl.emit     = 1'b1;
               ctrl.last     = 1'b1;
               ctrl.elem_sel = bdq_pkg::EL_READ;
               ctrl.cnt_dec  = 1'b1;
            end else if (stat.match) begin
               ctrl.save_elem = 1'b1;
               ctrl.rd_en     = 1'b1;
               ctrl.rd_sel    = bdq_pkg::RD_NEXT;
               ctrl.idx_inc   = 1'b1;
            end else if (stat.idx_last) begin
               ctrl.emit   = 1'b1;
               ctrl.last   = 1'b1;
               ctrl.status = bdq_pkg::ST_NOT_FOUND;
            end else begin
               ctrl.rd_en   = 1'b1;
               ctrl.rd_sel  = bdq_pkg::RD_NEXT;
               ctrl.idx_inc = 1'b1;
            end
         end
         bdq_pkg::S_SHIFT: begin
            // move the entry just read one place toward the front
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = bdq_pkg::WR_PREV;
            if (stat.idx_last) begin
               ctrl.emit     = 1'b1;
               ctrl.last     = 1'b1;
               ctrl.elem_sel = bdq_pkg::EL_SAVED;
               ctrl.cnt_dec  = 1'b1;
            end else begin
               ctrl.rd_en   = 1'b1;
               ctrl.rd_sel  = bdq_pkg::RD_NEXT;
               ctrl.idx_inc = 1'b1;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/bdq_datapath.sv =====
module bdq_datapath #(
   parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic signed [31:0]          req_value,
   input  bdq_pkg::dp_ctrl_type        ctrl,
   output bdq_pkg::dp_stat_type        stat,
   output logic                        rsp_strobe,
   output logic signed [31:0]          rsp_element,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_last
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = CNT_W + 1;

   logic [31:0]      entries_ff [CAPACITY];
   logic [31:0]      rd_data_ff;
   logic [31:0]      value_ff;
   logic [31:0]      elem_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] rd_addr, wr_addr, head_prev;
   logic [31:0]      wr_data;
   logic             strobe_ff;
   logic [31:0]      element_ff;
   logic [1:0]       status_ff;
   logic             last_ff;

   // ring position of an offset from the head
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(offset);
      if (sum >= SUM_W'(CAPACITY)) sum = sum - SUM_W'(CAPACITY);
      return sum[IDX_W-1:0];
   endfunction

   assign head_prev = (head_ff == '0) ? IDX_W'(CAPACITY - 1) : head_ff - IDX_W'(1);

   // status to controller
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == CNT_W'(CAPACITY));
   assign stat.match    = (rd_data_ff == value_ff);
   assign stat.idx_last = ((idx_ff + CNT_W'(1)) == count_ff);

   // address and data selection
   always_comb begin
      case (ctrl.rd_sel)
         bdq_pkg::RD_FRONT: rd_addr = head_ff;
         bdq_pkg::RD_BACK:  rd_addr = slot_of(head_ff, count_ff - CNT_W'(1));
         bdq_pkg::RD_NEXT:  rd_addr = slot_of(head_ff, idx_ff + CNT_W'(1));
         default:           rd_addr = head_ff;
      endcase
      case (ctrl.wr_sel)
         bdq_pkg::WR_FRONT: begin
            wr_addr = head_prev;
            wr_data = req_value;
         end
         bdq_pkg::WR_BACK: begin
            wr_addr = slot_of(head_ff, count_ff);
            wr_data = req_value;
         end
         bdq_pkg::WR_PREV: begin
            wr_addr = slot_of(head_ff, idx_ff - CNT_W'(1));
            wr_data = rd_data_ff;
         end
         default: begin
            wr_addr = head_ff;
            wr_data = req_value;
         end
      endcase
   end

   // entry storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) entries_ff[wr_addr] <= wr_data;
      if (ctrl.rd_en) rd_data_ff <= entries_ff[rd_addr];
   end

   // head, count and walk index updates
   always_comb begin
      head_in = head_ff;
      if (ctrl.head_dec) begin
         head_in = head_prev;
      end else if (ctrl.head_inc) begin
         head_in = slot_of(head_ff, CNT_W'(1));
      end
      count_in = count_ff;
      if (ctrl.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
      idx_in = idx_ff;
      if (ctrl.ld) begin
         idx_in = '0;
      end else if (ctrl.idx_inc) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // search key and removed element
   always_ff @(posedge clock) begin
      if (ctrl.ld) value_ff <= req_value;
      if (ctrl.save_elem) elem_ff <= rd_data_ff;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctrl.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         case (ctrl.elem_sel)
            bdq_pkg::EL_READ:  element_ff <= rd_data_ff;
            bdq_pkg::EL_SAVED: element_ff <= elem_ff;
            default:           element_ff <= '0;
         endcase
         status_ff <= ctrl.status;
         last_ff   <= ctrl.last;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_element = element_ff;
   assign rsp_status  = status_ff;
   assign rsp_last    = last_ff;

endmodule

// ===== rtl/bounded_deque_with_value_delete.sv =====
// Channel    Ports                                           Handshake
// request    req_command, req_value                          start & !busy
// response   rsp_element, rsp_status, rsp_last               rsp_strobe, one cycle
//
// Inserts, unused codes and any remove or show on an empty list finish in the
// accept cycle; a result, if any, appears in the next cycle and busy stays low.
// Remove front/back reads the end entry, then answers; show gives one entry per
// cycle from the single read port of the entry memory; remove by value searches,
// then closes the gap (search and shift share that read port).
// Synchronous active-high reset empties the list; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bounded_deque_with_value_delete #(
   parameter int CAPACITY = bdq_pkg::DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_element,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   bdq_pkg::dp_ctrl_type ctrl;
   bdq_pkg::dp_stat_type stat;

   bdq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .ctrl        (ctrl),
      .busy        (busy)
   );

   bdq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_value   (req_value),
      .ctrl        (ctrl),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_element (rsp_element),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== rtl/bdq_checker.sv =====
module bdq_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [2:0]         req_command,
   input logic               rsp_strobe,
   input logic signed [31:0] rsp_element,
   input logic [1:0]         rsp_status,
   input logic               rsp_last
);

   // an insert transaction answers in the next cycle, alone
   a_insert_one_cycle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == bdq_pkg::CMD_INS_FRONT ||
                         req_command == bdq_pkg::CMD_INS_BACK)
      |=> rsp_strobe && rsp_last && !busy)
      else $error("insert did not answer in one cycle");

   // a show burst has no gaps
   a_burst_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside a result burst");

   // error results carry no element and end the transaction
   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != bdq_pkg::ST_OK |-> rsp_element == 32'sd0 && rsp_last)
      else $error("error result with element or without last");

   // unused command codes do nothing
   a_unused_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command > bdq_pkg::CMD_REM_VALUE)
      |=> !rsp_strobe && !busy)
      else $error("unused command produced activity");

   // busy only rises after an accepted show or remove
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start) && $past(req_command) >= bdq_pkg::CMD_SHOW
                      && $past(req_command) <= bdq_pkg::CMD_REM_VALUE)
      else $error("busy rose without a show or remove transaction");

endmodule

bind bounded_deque_with_value_delete bdq_checker u_bdq_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_strobe  (rsp_strobe),
   .rsp_element (rsp_element),
   .rsp_status  (rsp_status),
   .rsp_last    (rsp_last)
);

// ===== sim/tb_bounded_deque_with_value_delete.sv =====
`timescale 1ns / 1ps

module tb_bounded_deque_with_value_delete;

   localparam int CAPACITY     = bdq_pkg::DEF_CAPACITY;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
   localparam int REPORT_MAX   = 10;

   // codes the block must ignore
   localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
   localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

   localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;
   localparam logic signed [31:0] VAL_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_ABSENT = 32'sh1234_5678;

   typedef struct {
      logic signed [31:0]  element;
      bdq_pkg::status_type status;
      logic                last;
   } list_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_command;
   logic signed [31:0] req_value;
   logic               rsp_strobe;
   logic signed [31:0] rsp_element;
   logic [1:0]         rsp_status;
   logic               rsp_last;

   // shadow copy of the list
   logic signed [31:0] list_mem [CAPACITY];
   int                 list_head;
   int                 list_count;
   list_result_type    expected_results [$];

   int mismatch_count;
   int cycle_count;

   bounded_deque_with_value_delete #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_command(req_command),
      .req_value  (req_value),
      .rsp_strobe (rsp_strobe),
      .rsp_element(rsp_element),
      .rsp_status (rsp_status),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ring position of the entry at a given offset from the front
   function automatic int slot_of(int offset);
      return (list_head + offset) % CAPACITY;
   endfunction

   function automatic void expect_result(logic signed [31:0] element,
                                         bdq_pkg::status_type status, logic last);
      list_result_type r;
      r.element = element;
      r.status  = status;
      r.last    = last;
      expected_results.push_back(r);
   endfunction

   // apply one accepted command to the shadow list, queue its results
   function automatic void predict_list_command(logic [2:0] cmd, logic signed [31:0] val);
      int                 pos;
      logic signed [31:0] removed;
      case (cmd)
         bdq_pkg::CMD_INS_FRONT, bdq_pkg::CMD_INS_BACK: begin
            if (list_count >= CAPACITY) begin
               expect_result('0, bdq_pkg::ST_FULL, 1'b1);
            end else begin
               if (cmd == bdq_pkg::CMD_INS_FRONT) begin
                  list_head = (list_head + CAPACITY - 1) % CAPACITY;
                  list_mem[list_head] = val;
               end else begin
                  list_mem[slot_of(list_count)] = val;
               end
               list_count++;
               expect_result('0, bdq_pkg::ST_OK, 1'b1);
            end
         end
         bdq_pkg::CMD_SHOW: begin
            if (list_count == 0)
               expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
            for (int i = 0; i < list_count; i++)
               expect_result(list_mem[slot_of(i)], bdq_pkg::ST_OK, i == list_count - 1);
         end
         bdq_pkg::CMD_REM_FRONT: begin
            if (list_count == 0) begin
               expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
            end else begin
               expect_result(list_mem[list_head], bdq_pkg::ST_OK, 1'b1);
               list_head = slot_of(1);
               list_count--;
            end
         end
         bdq_pkg::CMD_REM_BACK: begin
            if (list_count == 0) begin
               expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
            end else begin
               expect_result(list_mem[slot_of(list_count - 1)], bdq_pkg::ST_OK, 1'b1);
               list_count--;
            end
         end
         bdq_pkg::CMD_REM_VALUE: begin
            if (list_count == 0) begin
               expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
            end else begin
               pos = 0;
               while (pos < list_count && list_mem[slot_of(pos)] !== val)
                  pos++;
               if (pos == list_count) begin
                  expect_result('0, bdq_pkg::ST_NOT_FOUND, 1'b1);
               end else begin
                  removed = list_mem[slot_of(pos)];
                  // close the gap toward the front
                  for (int i = pos; i + 1 < list_count; i++)
                     list_mem[slot_of(i)] = list_mem[slot_of(i + 1)];
                  list_count--;
                  expect_result(removed, bdq_pkg::ST_OK, 1'b1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // mix of extremes, small values (duplicates likely) and full-range values
   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom_range(0, 6) - 3;
         2:       return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
         default: return $urandom_range(0, 15);
      endcase
   endfunction

   // drive one transaction and hold it until the block takes it
   task automatic send_list_command(input logic [2:0] cmd, input logic signed [31:0] val);
      @(negedge clock);
      start       <= 1'b1;
      req_command <= cmd;
      req_value   <= val;
      do begin
         @(posedge clock);
      end while (busy);
      predict_list_command(cmd, val);
   endtask

   task automatic idle_burst();
      @(negedge clock);
      start <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clock);
   endtask

   // every show and remove command on an empty list, plus the ignored codes
   task automatic test_empty_list();
      send_list_command(bdq_pkg::CMD_SHOW, '0);
      send_list_command(bdq_pkg::CMD_REM_FRONT, '0);
      send_list_command(bdq_pkg::CMD_REM_BACK, '0);
      send_list_command(bdq_pkg::CMD_REM_VALUE, '0);
      send_list_command(CMD_UNUSED_6, -32'sd1);
      send_list_command(CMD_UNUSED_7, VAL_MAX);
   endtask

   // single-entry removal from the back, and by value at the head
   task automatic test_single_entry();
      send_list_command(bdq_pkg::CMD_INS_BACK, VAL_MIN);
      send_list_command(bdq_pkg::CMD_REM_BACK, '0);
      send_list_command(bdq_pkg::CMD_INS_FRONT, VAL_MAX);
      send_list_command(bdq_pkg::CMD_REM_VALUE, VAL_MAX);
   endtask

   // fill to capacity, reject inserts, show, delete by value (ends, duplicate, absent), pop both ends
   task automatic test_full_list();
      logic signed [31:0] val;
      for (int k = 0; k < CAPACITY; k++) begin
         case (k)
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            2, 5:    val = -32'sd1;
            3:       val = '0;
            default: val = {8'hA5, 24'($urandom)};
         endcase
         send_list_command((k % 2 == 0) ? bdq_pkg::CMD_INS_FRONT : bdq_pkg::CMD_INS_BACK,
                           val);
      end
      send_list_command(bdq_pkg::CMD_INS_BACK, 32'sd1);
      send_list_command(bdq_pkg::CMD_INS_FRONT, 32'sd2);
      send_list_command(bdq_pkg::CMD_SHOW, '0);
      send_list_command(bdq_pkg::CMD_REM_VALUE, list_mem[slot_of(0)]);
      send_list_command(bdq_pkg::CMD_REM_VALUE, list_mem[slot_of(list_count - 1)]);
      // duplicate present: the one nearer the front goes
      send_list_command(bdq_pkg::CMD_REM_VALUE, -32'sd1);
      send_list_command(bdq_pkg::CMD_REM_VALUE, VAL_ABSENT);
      send_list_command(bdq_pkg::CMD_REM_FRONT, '0);
      send_list_command(bdq_pkg::CMD_REM_BACK, '0);
   endtask

   // random commands; insert_pct steers the list toward full or empty
   task automatic test_random_traffic(input int num_items, input int insert_pct,
                                      input bit with_idle);
      int                 sent;
      int                 pick;
      logic [2:0]         cmd;
      logic signed [31:0] val;
      sent = 0;
      while (sent < num_items) begin
         pick = $urandom_range(0, 99);
         val  = random_value();
         if (pick < 3) begin
            cmd = ($urandom_range(0, 1) != 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
         end else if (pick < 3 + insert_pct) begin
            cmd = ($urandom_range(0, 1) != 0) ? bdq_pkg::CMD_INS_FRONT
                                               : bdq_pkg::CMD_INS_BACK;
            sent++;
         end else if (pick < 12 + insert_pct) begin
            cmd = bdq_pkg::CMD_SHOW;
            sent++;
         end else begin
            case ($urandom_range(0, 2))
               0: cmd = bdq_pkg::CMD_REM_FRONT;
               1: cmd = bdq_pkg::CMD_REM_BACK;
               default: begin
                  cmd = bdq_pkg::CMD_REM_VALUE;
                  // mostly delete something that is there
                  if (list_count > 0 && $urandom_range(0, 3) != 0)
                     val = list_mem[slot_of($urandom_range(0, list_count - 1))];
               end
            endcase
            sent++;
         end
         send_list_command(cmd, val);
         if (with_idle && $urandom_range(0, 3) == 0)
            idle_burst();
      end
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result: element %0d status %0d last %0b",
                        rsp_element, rsp_status, rsp_last);
         end else begin
            want = expected_results.pop_front();
            if (rsp_element !== want.element || rsp_status !== want.status
                || rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("mismatch: expected element %0d status %0d last %0b, got %0d %0d %0b",
                           want.element, want.status, want.last,
                           rsp_element, rsp_status, rsp_last);
            end
         end
      end
   end

   // run-away guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      start          = 1'b0;
      req_command    = bdq_pkg::CMD_INS_FRONT;
      req_value      = '0;
      reset          = 1'b1;
      list_head      = 0;
      list_count     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_single_entry();
      test_full_list();
      test_random_traffic(30, 70, 1'b1);
      test_random_traffic(25, 25, 1'b1);
      test_random_traffic(15, 50, 1'b1);
      test_random_traffic(15, 50, 1'b0);

      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_datapath.sv
rtl/bounded_deque_with_value_delete.sv
rtl/bdq_checker.sv
sim/tb_bounded_deque_with_value_delete.sv
